/* rtl/qfds_pkg.sv */
// ============================================================================
// qfds_pkg
// Shared types for the quick-find disjoint set block: datapath operations
// and the command and status bundles between controller and datapath.
// ============================================================================
`timescale 1ns / 1ps

package qfds_pkg;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_LOAD,
        OP_RD_A,
        OP_RD_B,
        OP_CMP,
        OP_CNT_B,
        OP_DECIDE,
        OP_SCAN,
        OP_WR_KEEP,
        OP_WR_GONE,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic range_bad;
        logic is_query;
        logic same_group;
        logic idx_last;
        logic out_free;
    } dp_status_t;

endpackage

/* rtl/qfds_dp.sv */
// ============================================================================
// qfds_dp
// Datapath: label and size stores, item registers, scan pipeline and the
// result register driving the master channel.
// ============================================================================
`timescale 1ns / 1ps

module qfds_dp #(
    parameter int NODES = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  qfds_pkg::dp_cmd_t    cmd,
    output qfds_pkg::dp_status_t status,
    input  logic                 s_func,
    input  logic [7:0]           s_first,
    input  logic [7:0]           s_second,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic                 m_answer,
    output logic [7:0]           m_survivor
);

    localparam int LW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CW = $clog2(NODES + 1);

    logic [LW-1:0] lbl_mem [NODES];
    logic [CW-1:0] cnt_mem [NODES];

    logic          func_reg;
    logic [7:0]    a_reg;
    logic [7:0]    b_reg;
    logic [LW-1:0] idx_reg;
    logic [LW-1:0] lbl_rd_reg;
    logic [CW-1:0] cnt_rd_reg;
    logic [LW-1:0] ga_reg;
    logic [LW-1:0] gb_reg;
    logic [CW-1:0] cnta_reg;
    logic [LW-1:0] keep_reg;
    logic [LW-1:0] gone_reg;
    logic [CW-1:0] sum_reg;
    logic          scan_vld_reg;
    logic [LW-1:0] scan_addr_reg;
    logic          m_valid_reg;
    logic          m_answer_reg;
    logic [7:0]    m_survivor_reg;

    logic [LW-1:0] lbl_raddr;
    logic [LW-1:0] cnt_raddr;
    logic          range_bad;
    logic          merged;
    logic [LW-1:0] surv_lbl;
    logic          swap;

    assign range_bad = (32'(a_reg) >= NODES) || (32'(b_reg) >= NODES);
    assign merged    = !func_reg && (ga_reg != gb_reg);
    assign surv_lbl  = (merged && (ga_reg == gone_reg)) ? keep_reg : ga_reg;
    assign swap      = cnta_reg < cnt_rd_reg;

    always_comb begin
        case (cmd.op)
            qfds_pkg::OP_RD_A: lbl_raddr = LW'(a_reg);
            qfds_pkg::OP_RD_B: lbl_raddr = LW'(b_reg);
            default:           lbl_raddr = idx_reg;
        endcase
        cnt_raddr = (cmd.op == qfds_pkg::OP_CNT_B) ? gb_reg : ga_reg;
    end

    always_ff @(posedge aclk) begin
        lbl_rd_reg <= lbl_mem[lbl_raddr];
        if (cmd.op == qfds_pkg::OP_INIT) begin
            lbl_mem[idx_reg] <= idx_reg;
        end else if (scan_vld_reg && (lbl_rd_reg == gone_reg)) begin
            lbl_mem[scan_addr_reg] <= keep_reg;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_rd_reg <= cnt_mem[cnt_raddr];
        case (cmd.op)
            qfds_pkg::OP_INIT:    cnt_mem[idx_reg]  <= CW'(1);
            qfds_pkg::OP_WR_KEEP: cnt_mem[keep_reg] <= sum_reg;
            qfds_pkg::OP_WR_GONE: cnt_mem[gone_reg] <= '0;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            qfds_pkg::OP_LOAD: begin
                func_reg <= s_func;
                a_reg    <= s_first;
                b_reg    <= s_second;
            end
            qfds_pkg::OP_RD_B: ga_reg <= lbl_rd_reg;
            qfds_pkg::OP_CMP:  gb_reg <= lbl_rd_reg;
            qfds_pkg::OP_CNT_B: cnta_reg <= cnt_rd_reg;
            qfds_pkg::OP_DECIDE: begin
                keep_reg <= swap ? gb_reg : ga_reg;
                gone_reg <= swap ? ga_reg : gb_reg;
                sum_reg  <= cnta_reg + cnt_rd_reg;
            end
            default: ;
        endcase
        scan_addr_reg <= idx_reg;
        if (cmd.op == qfds_pkg::OP_OUT) begin
            m_answer_reg   <= range_bad ? 1'b0
                            : (func_reg ? (ga_reg == gb_reg) : merged);
            m_survivor_reg <= range_bad ? 8'd0 : 8'(surv_lbl);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            scan_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            case (cmd.op)
                qfds_pkg::OP_INIT,
                qfds_pkg::OP_SCAN: idx_reg <= idx_reg + 1'b1;
                qfds_pkg::OP_DECIDE: idx_reg <= '0;
                default: ;
            endcase
            scan_vld_reg <= (cmd.op == qfds_pkg::OP_SCAN);
            if (cmd.op == qfds_pkg::OP_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.range_bad  = range_bad;
    assign status.is_query   = func_reg;
    assign status.same_group = (ga_reg == lbl_rd_reg);
    assign status.idx_last   = (32'(idx_reg) == NODES - 1);
    assign status.out_free   = !m_valid_reg || m_ready;

    assign m_valid    = m_valid_reg;
    assign m_answer   = m_answer_reg;
    assign m_survivor = m_survivor_reg;

endmodule

/* rtl/qfds_ctrl.sv */
// ============================================================================
// qfds_ctrl
// Controller: clearing pass after reset, then per-transaction sequencing of
// label reads, size lookup, relabel scan and size update.
// ============================================================================
`timescale 1ns / 1ps

module qfds_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output qfds_pkg::dp_cmd_t    cmd,
    input  qfds_pkg::dp_status_t status
);

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_CMP,
        ST_CNT_B,
        ST_DECIDE,
        ST_SCAN,
        ST_DRAIN,
        ST_WR_KEEP,
        ST_WR_GONE,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd.op     = qfds_pkg::OP_NONE;
        unique case (state_reg)
            ST_INIT: begin
                cmd.op = qfds_pkg::OP_INIT;
                if (status.idx_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = qfds_pkg::OP_LOAD;
                    state_next = ST_RD_A;
                end
            end
            ST_RD_A: begin
                cmd.op     = qfds_pkg::OP_RD_A;
                state_next = status.range_bad ? ST_DONE : ST_RD_B;
            end
            ST_RD_B: begin
                cmd.op     = qfds_pkg::OP_RD_B;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                cmd.op = qfds_pkg::OP_CMP;
                if (status.is_query || status.same_group) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_CNT_B;
                end
            end
            ST_CNT_B: begin
                cmd.op     = qfds_pkg::OP_CNT_B;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.op     = qfds_pkg::OP_DECIDE;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.op = qfds_pkg::OP_SCAN;
                if (status.idx_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_WR_KEEP;
            end
            ST_WR_KEEP: begin
                cmd.op     = qfds_pkg::OP_WR_KEEP;
                state_next = ST_WR_GONE;
            end
            ST_WR_GONE: begin
                cmd.op     = qfds_pkg::OP_WR_GONE;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.op     = qfds_pkg::OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

/* rtl/quick_find_disjoint_sets.sv */
// ============================================================================
// quick_find_disjoint_sets
// Quick-find disjoint sets with union by size over NODES elements.
//
// Slave channel: one transaction names two elements and an operation
// (tuser 0 = merge the groups, 1 = ask whether both share a group).
// Master channel: one result transaction per input transaction, in order.
// A merge of two different groups runs the relabel scan, which reads and
// rewrites one label store entry per cycle; queries, merges within one
// group and items naming an element not below NODES skip the scan.
// One item is worked on at a time; the next is accepted once the result is
// in the output register, which holds while m_tready is low. When the
// receiver stalls with a result still held, the following result waits.
// After reset a clearing pass loads the stores (label k = k, size 1);
// s_tready stays low until it ends.
// ============================================================================
`timescale 1ns / 1ps

module quick_find_disjoint_sets #(
    parameter int NODES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] first_node, [15:8] second_node
    input  logic        s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] answer, [8:1] survivor_group, [15:9] zero
);

    qfds_pkg::dp_cmd_t    cmd;
    qfds_pkg::dp_status_t status;
    logic                 answer;
    logic [7:0]           survivor;

    qfds_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .cmd     (cmd),
        .status  (status)
    );

    qfds_dp #(
        .NODES (NODES)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .s_func     (s_tuser),
        .s_first    (s_tdata[7:0]),
        .s_second   (s_tdata[15:8]),
        .m_ready    (m_tready),
        .m_valid    (m_tvalid),
        .m_answer   (answer),
        .m_survivor (survivor)
    );

    assign m_tdata = {7'd0, survivor, answer};

endmodule

/* test/tb_top.sv */
// ============================================================================
// tb_top
// Self-checking bench for quick_find_disjoint_sets. Runs a scripted merge and
// query sequence, then random traffic under three backpressure profiles.
// Results are checked against script rows or an in-bench union-by-size model.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;

    localparam int NODES         = 256;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DIRECTED_ROWS = 22;
    localparam int RANDOM_ITEMS  = 183;

    typedef enum logic {
        FN_MERGE = 1'b0,
        FN_QUERY = 1'b1
    } set_fn_t;

    typedef struct packed {
        logic       answer;
        logic [7:0] survivor_group;
    } verdict_t;

    typedef struct packed {
        set_fn_t    fn;
        logic [7:0] first_node;
        logic [7:0] second_node;
        logic       typed;
        verdict_t   want;
    } script_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    logic [7:0] label_of [NODES];
    logic [8:0] size_of  [NODES];
    verdict_t   pending_verdicts [$];

    int errors;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;

    script_row_t directed_script [DIRECTED_ROWS] = '{
        '{FN_QUERY, 8'd0,   8'd255, 1'b1, '{1'b0, 8'd0}},
        '{FN_QUERY, 8'd7,   8'd7,   1'b1, '{1'b1, 8'd7}},
        '{FN_MERGE, 8'd0,   8'd255, 1'b1, '{1'b1, 8'd0}},
        '{FN_MERGE, 8'd255, 8'd0,   1'b1, '{1'b0, 8'd0}},
        '{FN_QUERY, 8'd255, 8'd0,   1'b1, '{1'b1, 8'd0}},
        '{FN_MERGE, 8'd254, 8'd0,   1'b1, '{1'b1, 8'd0}},
        '{FN_MERGE, 8'd3,   8'd4,   1'b1, '{1'b1, 8'd3}},
        '{FN_MERGE, 8'd4,   8'd3,   1'b1, '{1'b0, 8'd3}},
        '{FN_MERGE, 8'd200, 8'd201, 1'b1, '{1'b1, 8'd200}},
        '{FN_MERGE, 8'd201, 8'd4,   1'b1, '{1'b1, 8'd200}},
        '{FN_MERGE, 8'd3,   8'd255, 1'b1, '{1'b1, 8'd200}},
        '{FN_QUERY, 8'd0,   8'd201, 1'b1, '{1'b1, 8'd200}},
        '{FN_QUERY, 8'd128, 8'd127, 1'b1, '{1'b0, 8'd128}},
        '{FN_MERGE, 8'd128, 8'd127, 1'b1, '{1'b1, 8'd128}},
        '{FN_MERGE, 8'd1,   8'd128, 1'b0, '{1'b0, 8'd0}},
        '{FN_MERGE, 8'd170, 8'd85,  1'b0, '{1'b0, 8'd0}},
        '{FN_QUERY, 8'd85,  8'd170, 1'b0, '{1'b0, 8'd0}},
        '{FN_MERGE, 8'd128, 8'd0,   1'b0, '{1'b0, 8'd0}},
        '{FN_QUERY, 8'd1,   8'd254, 1'b0, '{1'b0, 8'd0}},
        '{FN_MERGE, 8'd255, 8'd255, 1'b0, '{1'b0, 8'd0}},
        '{FN_QUERY, 8'd255, 8'd255, 1'b0, '{1'b0, 8'd0}},
        '{FN_QUERY, 8'd2,   8'd253, 1'b0, '{1'b0, 8'd0}}
    };

    quick_find_disjoint_sets #(
        .NODES(NODES)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // [7:0] first_node, [15:8] second_node
        .s_tuser (s_tuser),   // [0] func
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)    // [0] answer, [8:1] survivor_group, [15:9] zero
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic verdict_t merge_or_query(set_fn_t fn, logic [7:0] a, logic [7:0] b);
        verdict_t   v;
        logic [7:0] ga;
        logic [7:0] gb;
        logic [7:0] keep;
        logic [7:0] gone;
        v = '0;
        if (int'(a) >= NODES || int'(b) >= NODES) begin
            return v;
        end
        ga = label_of[a];
        gb = label_of[b];
        if (fn == FN_QUERY) begin
            v.answer = (ga == gb);
        end else if (ga != gb) begin
            keep = ga;
            gone = gb;
            if (size_of[ga] < size_of[gb]) begin
                keep = gb;
                gone = ga;
            end
            for (int k = 0; k < NODES; k++) begin
                if (label_of[k] == gone) begin
                    label_of[k] = keep;
                end
            end
            size_of[keep] = size_of[keep] + size_of[gone];
            size_of[gone] = '0;
            v.answer = 1'b1;
        end
        v.survivor_group = label_of[a];
        return v;
    endfunction

    task automatic send_item(set_fn_t fn, logic [7:0] a, logic [7:0] b,
                             logic typed, verdict_t want);
        verdict_t predicted;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tuser  <= fn;
        do @(posedge aclk); while (!s_tready);
        predicted = merge_or_query(fn, a, b);
        pending_verdicts.insert(pending_verdicts.size(), typed ? want : predicted);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_node();
        logic [7:0] n;
        if ($urandom_range(99) < 40) begin
            n = 8'($urandom_range(255));
        end else begin
            n = 8'($urandom_range(31));
            if ($urandom_range(1) == 1) begin
                n = n | 8'hE0;
            end
        end
        return n;
    endfunction

    task automatic random_phase(int idle_pct, int stall_pct);
        set_fn_t fn;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            fn = ($urandom_range(99) < 55) ? FN_MERGE : FN_QUERY;
            send_item(fn, pick_node(), pick_node(), 1'b0, '0);
        end
        drain_results();
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_verdicts.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin : result_check
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result transaction, tdata %h", $time, m_tdata);
                errors++;
            end else begin
                want = pending_verdicts.pop_front();
                if (m_tdata[0] !== want.answer) begin
                    $display("%0t: answer expected %0d got %0d",
                             $time, want.answer, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[8:1] !== want.survivor_group) begin
                    $display("%0t: survivor_group expected %0d got %0d",
                             $time, want.survivor_group, m_tdata[8:1]);
                    errors++;
                end
                if (m_tdata[15:9] !== 7'd0) begin
                    $display("%0t: tdata padding expected 0 got %h", $time, m_tdata[15:9]);
                    errors++;
                end
            end
        end
    end

    initial begin
        errors         = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= FN_MERGE;
        for (int k = 0; k < NODES; k++) begin
            label_of[k] = 8'(k);
            size_of[k]  = 9'd1;
        end
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct  = 34;
        recv_stall_pct = 54;
        foreach (directed_script[i]) begin
            send_item(directed_script[i].fn, directed_script[i].first_node,
                      directed_script[i].second_node, directed_script[i].typed,
                      directed_script[i].want);
        end
        drain_results();

        random_phase(34, 54);
        random_phase(54, 34);
        random_phase(0, 0);

        repeat (NODES + 16) @(posedge aclk);
        if (pending_verdicts.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_verdicts.size());
            errors++;
        end
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
